FILE: rtl/assert_macros.svh
// assertion helpers for the rtl, included by dpq_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge of clk outside reset
`define DPQ_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dpq assertion failed");

// checked at every rising edge of clk, reset included
`define DPQ_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error("dpq assertion failed");

`endif

FILE: rtl/dpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_pkg
// types and constants of the double-ended priority queue
// ----------------------------------------------------------------------------
package dpq_pkg;

	// capacity must be a power of two (circular addressing)
	localparam int CAPACITY = 64;
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int DATA_W = 32;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELMIN = 2'd1;
	localparam logic [1:0] OP_DELMAX = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] op;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic signed [31:0] max_value;
		logic signed [31:0] min_value;
		logic [6:0] entry_count;
		logic is_empty;
	} rsp_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic signed [DATA_W-1:0] wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

endpackage
`default_nettype wire

FILE: rtl/double_ended_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// bounded min/max queue of signed 32-bit values over a sorted circular memory
//
//   channel  dir  payload  handshake
//   req      in   req_t    req_valid / req_stall
//   rsp      out  rsp_t    rsp_valid / rsp_stall
//
// one beat at a time; a delete reads back the new extreme, an insert shifts
// larger entries up (one memory read-modify-write per shifted entry)
// reset empties the queue at once; no clearing pass
// the result register lets the next beat enter while a result is stalled
// ----------------------------------------------------------------------------
module double_ended_priority_queue
	import dpq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rsp_t rsp
);

	logic req_ready;
	logic res_valid;
	logic res_ready;
	rsp_t res;
	mem_req_t mreq;
	logic signed [DATA_W-1:0] rdata;
	logic rsp_valid_q;
	rsp_t rsp_q;

	assign req_stall = !req_ready;
	assign res_ready = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	dpq_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mreq(mreq),
		.rdata(rdata)
	);

	dpq_mem u_mem (
		.clk(clk),
		.mreq(mreq),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dpq_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_mem
// entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module dpq_mem
	import dpq_pkg::*;
(
	input wire logic clk,
	input wire mem_req_t mreq,
	output logic signed [DATA_W-1:0] rdata
);

	logic signed [DATA_W-1:0] mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (mreq.we) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.re) begin
			rdata <= mem[mreq.raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dpq_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_core
// sorted circular list in memory; insert shifts entries one per cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dpq_core
	import dpq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire req_t req,
	output logic res_valid,
	input wire logic res_ready,
	output rsp_t res,
	output mem_req_t mreq,
	input wire logic signed [DATA_W-1:0] rdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS = 3'd1;
	localparam logic [2:0] S_LAST = 3'd2;
	localparam logic [2:0] S_FMIN = 3'd3;
	localparam logic [2:0] S_FMAX = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] pos_q;
	logic [ADDR_W-1:0] head_q;
	logic [1:0] status_q;
	logic signed [DATA_W-1:0] min_q;
	logic signed [DATA_W-1:0] max_q;
	logic signed [DATA_W-1:0] val_q;
	logic [ADDR_W-1:0] cnt_lo;
	logic [ADDR_W-1:0] pos_lo;
	logic is_full;

	assign cnt_lo = count_q[ADDR_W-1:0];
	assign pos_lo = pos_q[ADDR_W-1:0];
	assign is_full = (count_q >= CNT_W'(CAPACITY));
	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status = status_q;
		res.max_value = max_q;
		res.min_value = min_q;
		res.entry_count = 7'(count_q);
		res.is_empty = (count_q == '0);
	end

	always_comb begin
		mreq = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.op)
						OP_INSERT: begin
							if (count_q == '0) begin
								mreq.we = 1'b1;
								mreq.waddr = head_q;
								mreq.wdata = req.value;
							end else if (!is_full) begin
								mreq.re = 1'b1;
								mreq.raddr = head_q + cnt_lo - ADDR_W'(1);
							end
						end
						OP_DELMIN: begin
							if (count_q > CNT_W'(1)) begin
								mreq.re = 1'b1;
								mreq.raddr = head_q + ADDR_W'(1);
							end
						end
						OP_DELMAX: begin
							if (count_q > CNT_W'(1)) begin
								mreq.re = 1'b1;
								mreq.raddr = head_q + cnt_lo - ADDR_W'(2);
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INS: begin
				mreq.we = 1'b1;
				mreq.waddr = head_q + pos_lo;
				if (val_q < rdata) begin
					mreq.wdata = rdata;
					if (pos_q != CNT_W'(1)) begin
						mreq.re = 1'b1;
						mreq.raddr = head_q + pos_lo - ADDR_W'(2);
					end
				end else begin
					mreq.wdata = val_q;
				end
			end
			S_LAST: begin
				mreq.we = 1'b1;
				mreq.waddr = head_q;
				mreq.wdata = val_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			head_q <= '0;
			pos_q <= '0;
			status_q <= ST_DONE;
			min_q <= '0;
			max_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						val_q <= req.value;
						status_q <= ST_DONE;
						state_q <= S_DONE;
						case (req.op)
							OP_INSERT: begin
								if (is_full) begin
									status_q <= ST_FULL;
								end else if (count_q == '0) begin
									count_q <= CNT_W'(1);
									min_q <= req.value;
									max_q <= req.value;
								end else begin
									count_q <= count_q + CNT_W'(1);
									pos_q <= count_q;
									if (req.value < min_q) begin
										min_q <= req.value;
									end
									if (req.value >= max_q) begin
										max_q <= req.value;
									end
									state_q <= S_INS;
								end
							end
							OP_DELMIN: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q <= count_q - CNT_W'(1);
									head_q <= head_q + ADDR_W'(1);
									if (count_q == CNT_W'(1)) begin
										min_q <= '0;
										max_q <= '0;
									end else begin
										state_q <= S_FMIN;
									end
								end
							end
							OP_DELMAX: begin
								if (count_q == '0) begin
									status_q <= ST_EMPTY;
								end else begin
									count_q <= count_q - CNT_W'(1);
									if (count_q == CNT_W'(1)) begin
										min_q <= '0;
										max_q <= '0;
									end else begin
										state_q <= S_FMAX;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS: begin
					if (val_q < rdata) begin
						pos_q <= pos_q - CNT_W'(1);
						if (pos_q == CNT_W'(1)) begin
							state_q <= S_LAST;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_LAST: begin
					state_q <= S_DONE;
				end
				S_FMIN: begin
					min_q <= rdata;
					state_q <= S_DONE;
				end
				S_FMAX: begin
					max_q <= rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`DPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))
	`DPQ_ASSERT(a_rw_apart, (mreq.we && mreq.re) |-> (mreq.waddr != mreq.raddr))
	`DPQ_ASSERT(a_order, (state_q == S_DONE && count_q != '0) |-> (min_q <= max_q))
	`DPQ_ASSERT(a_empty_zero, (state_q == S_DONE && count_q == '0) |-> (min_q == '0 && max_q == '0))

endmodule
`default_nettype wire

FILE: tb/dpq_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpq_checker
// watches both channels of the priority queue, keeps a sorted list of its own
// and compares every response beat with the expected status, extremes, count and empty flag
// ----------------------------------------------------------------------------
module dpq_checker
	import dpq_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_stall,
	input wire req_t req,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp,
	output int errors,
	output int pending,
	output int responses
);

	logic signed [31:0] shadow_list[$];
	rsp_t expected_rsp[$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	function automatic rsp_t apply_op(input req_t r);
		rsp_t o;
		int pos;
		o = '0;
		o.status = ST_DONE;
		if (r.op == OP_INSERT) begin
			if (shadow_list.size() >= CAPACITY) begin
				o.status = ST_FULL;
			end else begin
				pos = shadow_list.size();
				while (pos > 0 && r.value < shadow_list[pos - 1])
					pos--;
				shadow_list.insert(pos, r.value);
			end
		end else if (r.op == OP_DELMIN || r.op == OP_DELMAX) begin
			if (shadow_list.size() == 0)
				o.status = ST_EMPTY;
			else if (r.op == OP_DELMIN)
				void'(shadow_list.pop_front());
			else
				void'(shadow_list.pop_back());
		end
		if (shadow_list.size() == 0) begin
			o.is_empty = 1'b1;
		end else begin
			o.max_value = shadow_list[$];
			o.min_value = shadow_list[0];
		end
		o.entry_count = 7'(shadow_list.size());
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			errors = 0;
			responses = 0;
			shadow_list.delete();
			expected_rsp.delete();
			pending = 0;
		end else begin
			if (req_valid && !req_stall)
				expected_rsp.push_back(apply_op(req));
			if (rsp_valid && !rsp_stall) begin
				responses++;
				if (expected_rsp.size() == 0) begin
					report("unexpected beat", 0, 0);
				end else begin
					e = expected_rsp.pop_front();
					if (rsp.status !== e.status)
						report("status", rsp.status, e.status);
					if (rsp.max_value !== e.max_value)
						report("max_value", rsp.max_value, e.max_value);
					if (rsp.min_value !== e.min_value)
						report("min_value", rsp.min_value, e.min_value);
					if (rsp.entry_count !== e.entry_count)
						report("entry_count", rsp.entry_count, e.entry_count);
					if (rsp.is_empty !== e.is_empty)
						report("is_empty", rsp.is_empty, e.is_empty);
				end
			end
			pending = expected_rsp.size();
		end
	end

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// drives operation beats into the priority queue with random idling and
// back-pressure; the checker predicts every response and counts mismatches
// ----------------------------------------------------------------------------
module testbench;
	import dpq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;
	int errors;
	int pending;
	int responses;
	int cycles;
	int sender_idle_pct;
	int receiver_idle_pct;
	int hold_cycles;
	int sent;

	double_ended_priority_queue dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	dpq_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.errors(errors),
		.pending(pending),
		.responses(responses)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off while hold_cycles runs down
	always @(negedge clk) begin
		if (!arst_n)
			rsp_stall <= 1'b0;
		else if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else
			rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
	end

	task automatic send(input logic [1:0] op, input logic [31:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req.op <= op;
		req.value <= value;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [31:0] rand_value;
		case ($urandom_range(5))
			0: return 32'h8000_0000 + $urandom_range(3);
			1: return 32'h7fff_ffff - $urandom_range(3);
			2: return $urandom_range(8) - 4;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(input int n);
		int i;
		int r;
		logic [1:0] op;
		for (i = 0; i < n; i++) begin
			r = $urandom_range(99);
			// bias slightly toward inserts so the queue tends to grow
			if (r < 2)
				op = OP_UNUSED;
			else if (r < 52)
				op = OP_INSERT;
			else if (r < 76)
				op = OP_DELMIN;
			else
				op = OP_DELMAX;
			send(op, rand_value());
		end
	endtask

	initial begin
		int i;
		cycles = 0;
		sent = 0;
		hold_cycles = 0;
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: deletes on empty, extremes, duplicates, unused opcode
		send(OP_DELMIN, 32'h0);
		send(OP_DELMAX, 32'hffff_ffff);
		send(OP_INSERT, 32'h8000_0000);
		send(OP_INSERT, 32'h7fff_ffff);
		send(OP_INSERT, 32'h0);
		send(OP_INSERT, 32'hffff_ffff);
		send(OP_INSERT, 32'h7fff_ffff);
		send(OP_INSERT, 32'h8000_0000);
		send(OP_UNUSED, 32'h1234_5678);
		send(OP_DELMAX, 32'h0);
		send(OP_DELMIN, 32'h0);
		send(OP_DELMAX, 32'h0);
		send(OP_DELMIN, 32'h0);
		send(OP_DELMIN, 32'h0);
		send(OP_DELMAX, 32'h0);
		send(OP_DELMAX, 32'h0);
		send(OP_INSERT, 32'h5555_aaaa);
		send(OP_INSERT, 32'haaaa_5555);
		send(OP_DELMIN, 32'h0);
		send(OP_DELMIN, 32'h0);
		// fill to capacity, then one rejected insert, under a long hold-off
		hold_cycles = 300;
		for (i = 0; i < CAPACITY; i++)
			send(OP_INSERT, $urandom);
		send(OP_INSERT, 32'h1);
		drain();
		for (i = 0; i < CAPACITY; i++)
			send(i[0] ? OP_DELMAX : OP_DELMIN, 32'h0);
		drain();

		sender_idle_pct = 21;
		receiver_idle_pct = 55;
		random_phase(330);
		drain();
		sender_idle_pct = 55;
		receiver_idle_pct = 21;
		random_phase(330);
		drain();
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		random_phase(250);

		drain();
		repeat (CAPACITY + 20) @(posedge clk);
		$display("%0d operation beats sent, %0d response beats checked", sent, responses);
		$display("covered empty and full queues, extremes, duplicates and stalls");
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
`default_nettype wire
